// ----- src/aes_pkg.sv -----
// AES-128 package: payload structs, S-box tables, GF(2^8) helpers.
// Used by every module of the cipher unit; depends on nothing.
package aes_pkg;

    localparam int RoundCount = 10;
    localparam int KeyEntries = RoundCount + 1;
    localparam int QueueDepth = 2;

    localparam logic [7:0] Rcon1  = 8'h01;
    localparam logic [7:0] Poly   = 8'h1b;

    localparam logic CfgKeyHigh = 1'b0;
    localparam logic CfgKeyLow  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_core_state;

    typedef enum logic [1:0] {
        KS_IDLE,
        KS_RUN
    } t_ks_state;

    typedef struct packed {
        logic       busy;
        logic [3:0] index;
    } t_ks_status;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? Poly : 8'h00);
    endfunction

    // byte i of a 128-bit word sits at bits 127-8i .. 120-8i
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] = sbox(s[127-8*(4*((c+r)%4)+r) -: 8]);
        return o;
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] = inv_sbox(s[127-8*(4*((c+4-r)%4)+r) -: 8]);
        return o;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            o[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            o[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            o[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            o[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return o;
    endfunction

    // inverse = forward mix after a {05,00,04,00}-style pre-step
    function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
        logic [127:0] p;
        logic [7:0] a0, a1, a2, a3, u, v;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            u = xtime(xtime(a0 ^ a2));
            v = xtime(xtime(a1 ^ a3));
            p[127-32*c -: 8] = a0 ^ u;
            p[119-32*c -: 8] = a1 ^ v;
            p[111-32*c -: 8] = a2 ^ u;
            p[103-32*c -: 8] = a3 ^ v;
        end
        return mix_cols(p);
    endfunction

endpackage

// ----- src/aes_key_sched.sv -----
// AES key schedule: expands the key registers into the round key store,
// one round key per cycle. Depends on aes_pkg.
module aes_key_sched (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [127:0]         i_key,
    input  logic [3:0]           i_rd_index,
    output logic [127:0]         o_rd_key,
    output aes_pkg::t_ks_status  o_status
);

    logic [127:0] r_store [aes_pkg::KeyEntries];
    aes_pkg::t_ks_state r_state, n_state;
    logic [3:0]   r_index, n_index;
    logic [127:0] r_word, n_word;
    logic [7:0]   r_rcon, n_rcon;
    logic         w_we;
    logic [127:0] w_next;
    logic [31:0]  w_t;

    always_comb begin
        w_t = {aes_pkg::sbox(r_word[23:16]), aes_pkg::sbox(r_word[15:8]),
               aes_pkg::sbox(r_word[7:0]), aes_pkg::sbox(r_word[31:24])};
        w_t[31:24] = w_t[31:24] ^ r_rcon;
        w_next[127:96] = r_word[127:96] ^ w_t;
        w_next[95:64]  = r_word[95:64] ^ w_next[127:96];
        w_next[63:32]  = r_word[63:32] ^ w_next[95:64];
        w_next[31:0]   = r_word[31:0] ^ w_next[63:32];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            aes_pkg::KS_IDLE: if (i_start) n_state = aes_pkg::KS_RUN;
            aes_pkg::KS_RUN:  if (!i_start && r_index == 4'(aes_pkg::RoundCount))
                n_state = aes_pkg::KS_IDLE;
            default: n_state = aes_pkg::KS_IDLE;
        endcase
    end

    always_comb begin
        n_index = r_index;
        n_word  = r_word;
        n_rcon  = r_rcon;
        w_we    = 1'b0;
        if (i_start) begin
            n_index = 4'd0;
            n_word  = i_key;
            n_rcon  = aes_pkg::Rcon1;
            w_we    = 1'b1;
        end else if (r_state == aes_pkg::KS_RUN && r_index != 4'(aes_pkg::RoundCount)) begin
            n_index = r_index + 4'd1;
            n_word  = w_next;
            n_rcon  = aes_pkg::xtime(r_rcon);
            w_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aes_pkg::KS_RUN;
            r_index <= 4'd0;
            r_word  <= '0;
            r_rcon  <= aes_pkg::Rcon1;
        end else begin
            r_state <= n_state;
            r_index <= n_index;
            r_word  <= n_word;
            r_rcon  <= n_rcon;
        end
    end

    // store written in step with the running word; reset loads the zero key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_store[0] <= '0;
        else if (w_we) r_store[n_index] <= n_word;
    end

    assign o_rd_key = r_store[i_rd_index];
    assign o_status = '{busy: (r_state == aes_pkg::KS_RUN) || i_start, index: r_index};

endmodule

// ----- src/aes_front.sv -----
// Front end: accepts input beats into a two-entry queue.
// Depends on aes_pkg.
module aes_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  aes_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_take,
    output aes_pkg::t_in_item o_item
);

    aes_pkg::t_in_item r_q [aes_pkg::QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_stall = (r_cnt == 2'(aes_pkg::QueueDepth));
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_take;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_item;
    end

endmodule

// ----- src/aes_round_core.sv -----
// Back end: iterative round core, one round per cycle, with output register.
// Depends on aes_pkg.
module aes_round_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_take,
    input  aes_pkg::t_in_item   i_item,
    input  logic                i_ks_busy,
    output logic [3:0]          o_key_index,
    input  logic [127:0]        i_round_key,
    output logic                o_valid,
    input  logic                i_stall,
    output aes_pkg::t_out_item  o_item
);

    aes_pkg::t_core_state r_state, n_state;
    logic [3:0]   r_round;
    logic         r_dec;
    logic [127:0] r_data;
    logic [127:0] w_enc, w_dec;
    logic         w_start;
    logic         w_last;

    assign w_last  = (r_round == 4'(aes_pkg::RoundCount));
    assign w_start = (r_state == aes_pkg::ST_IDLE) && i_valid && !i_ks_busy;

    // key index: before start it points at the first key of the chosen direction
    always_comb begin
        if (r_state == aes_pkg::ST_IDLE)
            o_key_index = i_item.operation ? 4'(aes_pkg::RoundCount) : 4'd0;
        else
            o_key_index = r_dec ? 4'(aes_pkg::RoundCount) - r_round : r_round;
    end

    always_comb begin
        w_enc = aes_pkg::sub_shift(r_data);
        if (!w_last) w_enc = aes_pkg::mix_cols(w_enc);
        w_enc = w_enc ^ i_round_key;
        w_dec = aes_pkg::inv_shift_sub(r_data) ^ i_round_key;
        if (!w_last) w_dec = aes_pkg::inv_mix_cols(w_dec);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            aes_pkg::ST_IDLE: if (w_start) n_state = aes_pkg::ST_RUN;
            aes_pkg::ST_RUN:  if (w_last) n_state = aes_pkg::ST_DONE;
            aes_pkg::ST_DONE: if (!i_stall) n_state = aes_pkg::ST_IDLE;
            default: n_state = aes_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_take  = w_start;
        o_valid = (r_state == aes_pkg::ST_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aes_pkg::ST_IDLE;
            r_round <= 4'd0;
        end else begin
            r_state <= n_state;
            if (w_start) r_round <= 4'd1;
            else if (r_state == aes_pkg::ST_RUN && !w_last) r_round <= r_round + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_dec  <= i_item.operation;
            r_data <= {i_item.block_high, i_item.block_low} ^ i_round_key;
        end else if (r_state == aes_pkg::ST_RUN) begin
            r_data <= r_dec ? w_dec : w_enc;
        end
    end

    assign o_item = '{result_high: r_data[127:64], result_low: r_data[63:0]};

endmodule

// ----- src/aes128_block_cipher_unit.sv -----
// AES-128 cipher unit top level: key registers, front queue, key schedule
// and round core. Depends on aes_pkg and the aes_* submodules.
//
//  channel | dir | handshake          | payload
//  input   | in  | i_valid / o_stall  | i_item  (t_in_item)
//  output  | out | o_valid / i_stall  | o_item  (t_out_item)
//  config  | in  | i_cfg_we           | i_cfg_index, i_cfg_data
//
// In the round core a block gets the key addition, then ten rounds, one per
// cycle through the shared round logic, and is handed over from the output
// register; the core takes no new block until that result has gone out.
// After reset the schedule fills the store and holds blocks back; after a key
// write it does so again, from the cycle after the write. Output stall
// holds the result; the front queue keeps taking up to two beats.
module aes128_block_cipher_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  aes_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output aes_pkg::t_out_item o_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    logic [63:0] r_key_high, r_key_low;
    logic [127:0] w_key;
    logic r_restart;
    logic w_q_valid, w_take;
    aes_pkg::t_in_item w_q_item;
    logic [3:0]   w_key_index;
    logic [127:0] w_round_key;
    aes_pkg::t_ks_status w_ks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_restart  <= 1'b0;
        end else begin
            r_restart <= i_cfg_we;
            if (i_cfg_we && i_cfg_index == aes_pkg::CfgKeyHigh) r_key_high <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == aes_pkg::CfgKeyLow)  r_key_low  <= i_cfg_data;
        end
    end

    assign w_key = {r_key_high, r_key_low};

    aes_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (w_q_valid),
        .i_take  (w_take),
        .o_item  (w_q_item)
    );

    aes_key_sched u_ks (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_restart),
        .i_key      (w_key),
        .i_rd_index (w_key_index),
        .o_rd_key   (w_round_key),
        .o_status   (w_ks)
    );

    aes_round_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_take      (w_take),
        .i_item      (w_q_item),
        .i_ks_busy   (w_ks.busy),
        .o_key_index (w_key_index),
        .i_round_key (w_round_key),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

// ----- verif/aes128_block_cipher_unit_checker.sv -----
// Checker for the AES-128 cipher unit: watches input, output and key-write ports,
// predicts each result block and compares it with the one that comes out.
// Depends on aes_pkg for the payload types, the register index names and the S-box tables.
module aes128_block_cipher_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  aes_pkg::t_in_item  i_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  aes_pkg::t_out_item i_out_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);

    logic [7:0]   fwd_sb [256];
    logic [7:0]   inv_sb [256];
    logic [63:0]  key_hi, key_lo;
    logic [127:0] sched [11];
    aes_pkg::t_out_item expected_blocks [$];

    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] c);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (c[i]) acc ^= x;
            x = gf_dbl(x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    task automatic rebuild_schedule();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {fwd_sb[t[31:24]], fwd_sb[t[23:16]], fwd_sb[t[15:8]], fwd_sb[t[7:0]]};
                t[31:24] ^= rc;
                rc = gf_dbl(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int k = 0; k < 11; k++) sched[k] = {w[4*k], w[4*k+1], w[4*k+2], w[4*k+3]};
    endtask

    // dir 1: rotate rows left (encrypt), -1: right (decrypt); sub via chosen table
    function automatic logic [127:0] shift_sub(input logic [127:0] s, input int dir,
                                               input logic inv);
        logic [127:0] o;
        logic [7:0]   b;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                b = byte_at(s, 4*((c + dir*r + 4) & 3) + r);
                o[127-8*(4*c+r) -: 8] = inv ? inv_sb[b] : fwd_sb[b];
            end
        return o;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
        logic [7:0]   m [4];
        logic [127:0] o;
        logic [7:0]   a [4];
        m = inv ? '{8'h0e, 8'h0b, 8'h0d, 8'h09} : '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = byte_at(s, 4*c+r);
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] = gf_mul(a[0], m[(4-r)&3]) ^ gf_mul(a[1], m[(5-r)&3])
                                      ^ gf_mul(a[2], m[(6-r)&3]) ^ gf_mul(a[3], m[(7-r)&3]);
        end
        return o;
    endfunction

    function automatic aes_pkg::t_out_item cipher_block(input aes_pkg::t_in_item it);
        logic [127:0] s;
        s = {it.block_high, it.block_low};
        if (!it.operation) begin
            s ^= sched[0];
            for (int k = 1; k <= 10; k++) begin
                s = shift_sub(s, 1, 1'b0);
                if (k < 10) s = mix(s, 1'b0);
                s ^= sched[k];
            end
        end else begin
            s ^= sched[10];
            for (int k = 9; k >= 0; k--) begin
                s = shift_sub(s, -1, 1'b1);
                s ^= sched[k];
                if (k > 0) s = mix(s, 1'b1);
            end
        end
        return s;
    endfunction

    task automatic report(input string what, input aes_pkg::t_out_item got,
                          input aes_pkg::t_out_item want);
        o_errors++;
        $display("%s: got %h_%h want %h_%h", what, got.result_high, got.result_low,
                 want.result_high, want.result_low);
    endtask

    initial begin
        logic [7:0] v;
        for (int i = 0; i < 256; i++) begin
            v = 8'(i);
            fwd_sb[i] = aes_pkg::sbox(v);
            inv_sb[i] = aes_pkg::inv_sbox(v);
        end
    end

    assign o_pending = expected_blocks.size();

    always @(posedge i_clk) begin
        aes_pkg::t_out_item want;
        if (!i_rst_n) begin
            o_errors = 0;
            key_hi = '0;
            key_lo = '0;
            rebuild_schedule();
            expected_blocks.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_blocks.size() == 0) begin
                    report("unexpected result beat", i_out_item, '0);
                end else begin
                    want = expected_blocks.pop_front();
                    if (i_out_item.result_high !== want.result_high)
                        report("result_high", i_out_item, want);
                    else if (i_out_item.result_low !== want.result_low)
                        report("result_low", i_out_item, want);
                end
            end
            if (i_valid && !i_in_stall) expected_blocks.push_back(cipher_block(i_item));
            if (i_cfg_we) begin
                if (i_cfg_index == aes_pkg::CfgKeyHigh) key_hi = i_cfg_data;
                else key_lo = i_cfg_data;
                rebuild_schedule();
            end
        end
    end
endmodule

// ----- verif/aes128_block_cipher_unit_tb.sv -----
// Testbench top for the AES-128 cipher unit: clock, reset, key phases,
// directed and random block stimulus with random idling, and the verdict.
// Depends on aes_pkg, the unit and aes128_block_cipher_unit_checker.
module aes128_block_cipher_unit_tb;

    localparam int StallLimit = 5000;

    logic       clk;
    logic       rst_n;
    logic       in_valid, in_stall;
    aes_pkg::t_in_item  in_item;
    logic       out_valid, out_stall;
    aes_pkg::t_out_item out_item;
    logic       cfg_we, cfg_index;
    logic [63:0] cfg_data;
    int         errors, pending;
    int         quiet_cycles;
    logic       calm;

    aes128_block_cipher_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_item(in_item),
        .o_valid(out_valid), .i_stall(out_stall), .o_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    aes128_block_cipher_unit_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_in_stall(in_stall), .i_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stalls about 20% of cycles, except in calm stretches
    always @(posedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 20);

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit) begin
            $display("aes128_block_cipher_unit: mismatch");
            $finish;
        end
    end

    // leaves valid high after the beat; callers drop it before waiting
    task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
        while (!calm && $urandom_range(99) < 20) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{operation: op, block_high: hi, block_low: lo};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
        // wait for the core to drain, then margin for the last hand-over
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= aes_pkg::CfgKeyHigh; cfg_data <= hi;
        @(posedge clk);
        cfg_index <= aes_pkg::CfgKeyLow; cfg_data <= lo;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick64();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    initial begin
        rst_n = 1'b0; calm = 1'b0;
        in_valid = 1'b0; in_item = '0;
        cfg_we = 1'b0; cfg_index = aes_pkg::CfgKeyHigh; cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero key straight after reset
        send_block(1'b0, '0, '0);
        send_block(1'b1, '0, '0);
        send_block(1'b0, '1, '1);
        // standard test vector key, then extremes
        write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(1'b0, '1, '0);
        send_block(1'b1, '0, '1);
        write_key('1, '1);
        send_block(1'b0, '0, '0);
        send_block(1'b1, '1, '1);
        send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
        // key half-written: only the high half changes
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= aes_pkg::CfgKeyHigh; cfg_data <= 64'h2b7e151628aed2a6;
        @(posedge clk);
        cfg_we <= 1'b0;
        send_block(1'b0, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
        send_block(1'b1, 64'h3243f6a8885a308d, 64'h313198a2e0370734);

        for (int phase = 0; phase < 7; phase++) begin
            write_key(pick64(), pick64());
            calm = (phase == 3);
            for (int n = 0; n < 100; n++)
                send_block(1'($urandom_range(1)), pick64(), pick64());
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0) $display("aes128_block_cipher_unit: match");
        else $display("aes128_block_cipher_unit: mismatch");
        $finish;
    end
endmodule
